// ===== rtl/core/gf2_64_field_alu_core_macros.svh =====
// Assertion helpers included by the top-level core.
`ifndef GF2_64_FIELD_ALU_CORE_MACROS_SVH
`define GF2_64_FIELD_ALU_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GF64_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("gf64 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GF64_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("gf64 assertion failed");

`endif

// ===== rtl/core/gf64_pkg.sv =====
package gf64_pkg;

    localparam int unsigned ElemBits  = 64;
    localparam int unsigned OpBits    = 3;
    localparam int unsigned DigitBits = 8;
    localparam int unsigned DigitCnt  = ElemBits / DigitBits;
    localparam int unsigned CntBits   = $clog2(DigitCnt);

    typedef logic [ElemBits-1:0] elem_t;

    localparam elem_t POLY_LOW = 64'h0000_0000_0000_001B;
    // The inverse is taken as a^(2^64 - 2).
    localparam elem_t INV_EXP  = 64'hFFFF_FFFF_FFFF_FFFE;

    localparam logic [OpBits-1:0] OP_ADD = 3'd0;
    localparam logic [OpBits-1:0] OP_MUL = 3'd1;
    localparam logic [OpBits-1:0] OP_SQR = 3'd2;
    localparam logic [OpBits-1:0] OP_INV = 3'd3;
    localparam logic [OpBits-1:0] OP_POW = 3'd4;

    typedef struct packed {
        logic load;
        logic start;
        logic update;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic mul_done;
    } status_t;

endpackage

// ===== rtl/core/gf64_mul.sv =====
module gf64_mul (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  gf64_pkg::elem_t a,
    input  gf64_pkg::elem_t b,
    output gf64_pkg::elem_t product,
    output logic            done
);

    gf64_pkg::elem_t                  p_reg, p_next;
    gf64_pkg::elem_t                  a_reg;
    gf64_pkg::elem_t                  b_reg;
    logic [gf64_pkg::CntBits-1:0]     cnt_reg;
    logic                             busy_reg;

    // Most significant bits of b first: shift the partial product, reduce, add a.
    always_comb begin
        gf64_pkg::elem_t p;
        p = p_reg;
        for (int i = 0; i < gf64_pkg::DigitBits; i++) begin
            p = {p[gf64_pkg::ElemBits-2:0], 1'b0}
                ^ (p[gf64_pkg::ElemBits-1] ? gf64_pkg::POLY_LOW : '0)
                ^ (b_reg[gf64_pkg::ElemBits-1-i] ? a_reg : '0);
        end
        p_next = p;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            p_reg    <= '0;
            a_reg    <= a;
            b_reg    <= b;
        end else if (busy_reg) begin
            p_reg   <= p_next;
            b_reg   <= b_reg << gf64_pkg::DigitBits;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == gf64_pkg::CntBits'(gf64_pkg::DigitCnt - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign product = p_next;
    assign done    = busy_reg && (cnt_reg == gf64_pkg::CntBits'(gf64_pkg::DigitCnt - 1));

endmodule

// ===== rtl/core/gf64_datapath.sv =====
module gf64_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gf64_pkg::cmd_t                cmd,
    output gf64_pkg::status_t             status,
    input  logic [gf64_pkg::OpBits-1:0]   op,
    input  gf64_pkg::elem_t               operand_a,
    input  gf64_pkg::elem_t               operand_b,
    input  gf64_pkg::elem_t               exponent,
    output gf64_pkg::elem_t               result,
    output logic                          zero_inverse_error
);

    gf64_pkg::elem_t acc_reg, base_reg, exp_reg, res_reg;
    logic            err_reg, res_err_reg;
    gf64_pkg::elem_t prod_acc, prod_base;
    logic            done_acc, done_base;

    gf64_mul u_mul_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .a       (acc_reg),
        .b       (base_reg),
        .product (prod_acc),
        .done    (done_acc)
    );

    gf64_mul u_mul_base (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .a       (base_reg),
        .b       (base_reg),
        .product (prod_base),
        .done    (done_base)
    );

    // Every operation is folded into square-and-multiply rounds: the load
    // sets the accumulator and exponent so that the rounds finish the job.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= operand_a;
            err_reg  <= (op == gf64_pkg::OP_INV) && (operand_a == '0);
            case (op)
                gf64_pkg::OP_ADD: begin
                    acc_reg <= operand_a ^ operand_b;
                    exp_reg <= '0;
                end
                gf64_pkg::OP_MUL: begin
                    acc_reg <= operand_b;
                    exp_reg <= gf64_pkg::ElemBits'(1);
                end
                gf64_pkg::OP_SQR: begin
                    acc_reg <= operand_a;
                    exp_reg <= gf64_pkg::ElemBits'(1);
                end
                gf64_pkg::OP_INV: begin
                    acc_reg <= gf64_pkg::ElemBits'(1);
                    exp_reg <= gf64_pkg::INV_EXP;
                end
                gf64_pkg::OP_POW: begin
                    acc_reg <= gf64_pkg::ElemBits'(1);
                    exp_reg <= exponent;
                end
                default: begin
                    acc_reg <= '0;
                    exp_reg <= '0;
                end
            endcase
        end else if (cmd.update) begin
            if (exp_reg[0]) begin
                acc_reg <= prod_acc;
            end
            base_reg <= prod_base;
            exp_reg  <= exp_reg >> 1;
        end
        if (cmd.publish) begin
            res_reg     <= acc_reg;
            res_err_reg <= err_reg;
        end
    end

    assign status.exp_zero   = (exp_reg == '0);
    assign status.mul_done   = done_acc && done_base;
    assign result            = res_reg;
    assign zero_inverse_error = res_err_reg;

endmodule

// ===== rtl/core/gf64_ctrl.sv =====
module gf64_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  gf64_pkg::status_t status,
    output gf64_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb begin
        cmd         = '0;
        cmd.load    = (state_reg == ST_IDLE) && in_valid;
        cmd.start   = (state_reg == ST_CHECK) && !status.exp_zero;
        cmd.update  = (state_reg == ST_RUN) && status.mul_done;
        cmd.publish = (state_reg == ST_FIN) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // A new result takes the output slot in the cycle the old one leaves.
            if ((state_reg == ST_FIN) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    state_reg <= status.exp_zero ? ST_FIN : ST_RUN;
                end
                ST_RUN: begin
                    if (status.mul_done) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/gf2_64_field_alu_core.sv =====
// Channel | Direction | tdata                                   | tuser
// s_      | in        | operand_a, operand_b, exponent (192 b)  | op (3 b)
// m_      | out       | result (64 b)                           | zero_inverse_error
//
// One item at a time. Each square-and-multiply round uses the two
// 8-bit-per-cycle multipliers, one round per remaining exponent bit; power
// and inverse run up to 64 rounds, multiply and square one round, add and
// unused codes none.
// Reset is synchronous and active low. A result waiting on m_ does not block
// the next s_ transfer; only the final hand-off waits for the output slot.
`include "gf2_64_field_alu_core_macros.svh"

module gf2_64_field_alu_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // operand_a [63:0], operand_b [127:64], exponent [191:128]
    input  logic [2:0]   s_tuser,   // op [2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result [63:0]
    output logic [0:0]   m_tuser    // zero_inverse_error [0]
);

    gf64_pkg::cmd_t    cmd;
    gf64_pkg::status_t status;

    gf64_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    gf64_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .op                 (s_tuser),
        .operand_a          (s_tdata[63:0]),
        .operand_b          (s_tdata[127:64]),
        .exponent           (s_tdata[191:128]),
        .result             (m_tdata),
        .zero_inverse_error (m_tuser[0])
    );

    `GF64_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `GF64_ASSERT_IMP(a_err_gives_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 64'd0)
    `GF64_ASSERT_IMP(a_load_only_idle, aclk, aresetn, cmd.load, s_tready && !cmd.update)

endmodule
